// ----- hdl/wamsl_pkg.sv -----
// Package for the custom-section locator: phases, status codes, constants.
`default_nettype none
package wamsl_pkg;

  typedef enum logic [3:0] {
    PH_MAGIC     = 4'd0,
    PH_W_ID      = 4'd1,
    PH_W_SIZE    = 4'd2,
    PH_W_NAMELEN = 4'd3,
    PH_SKIP      = 4'd4,
    PH_NAME      = 4'd5,
    PH_TAIL      = 4'd6,
    PH_PAYLOAD   = 4'd7,
    PH_A_HDR     = 4'd8,
    PH_A_BODYHDR = 4'd9
  } phase_e;

  typedef enum logic [1:0] {
    ST_FOUND     = 2'd0,
    ST_NOT_FOUND = 2'd1,
    ST_BAD_MAGIC = 2'd2,
    ST_MALFORMED = 2'd3
  } status_e;

  localparam logic [7:0]  LebData       = 8'h7F;
  localparam logic [7:0]  LebMore       = 8'h80;
  localparam logic [31:0] AotCustomType = 32'd100;
  localparam logic [31:0] TargetLen     = 32'd15;

  // Input transaction as held in the input register.
  typedef struct packed {
    logic [7:0] image_byte;
    logic       start_req;
  } in_item_t;

  // Result transaction.
  typedef struct packed {
    logic       payload_valid;
    logic [7:0] payload_byte;
    logic       done_res;
    logic [1:0] status;
  } out_item_t;

  function automatic logic [7:0] target_char(input logic [3:0] idx);
    logic [7:0] c;
    case (idx)
      4'd0:    c = 8'h2E; // .
      4'd1:    c = 8'h61; // a
      4'd2:    c = 8'h6B; // k
      4'd3:    c = 8'h69; // i
      4'd4:    c = 8'h72; // r
      4'd5:    c = 8'h61; // a
      4'd6:    c = 8'h2E; // .
      4'd7:    c = 8'h6D; // m
      4'd8:    c = 8'h61; // a
      4'd9:    c = 8'h6E; // n
      4'd10:   c = 8'h69; // i
      4'd11:   c = 8'h66; // f
      4'd12:   c = 8'h65; // e
      4'd13:   c = 8'h73; // s
      4'd14:   c = 8'h74; // t
      default: c = 8'h00;
    endcase
    return c;
  endfunction

  function automatic logic [7:0] magic_char(input logic aot, input logic [1:0] idx);
    logic [7:0] c;
    case (idx)
      2'd0:    c = 8'h00;
      2'd1:    c = 8'h61;
      2'd2:    c = aot ? 8'h6F : 8'h73;
      default: c = aot ? 8'h74 : 8'h6D;
    endcase
    return c;
  endfunction

endpackage
`default_nettype wire

// ----- hdl/wamsl_scan.sv -----
// Scan state and combinational next-state logic for one image byte.
`default_nettype none
module wamsl_scan #(
  parameter int LENGTH_BITS = 24
) (
  input  wire logic                   clk_i,
  input  wire logic                   rst_ni,
  input  wire logic                   step_i,
  input  wire wamsl_pkg::in_item_t    item_i,
  input  wire logic [LENGTH_BITS-1:0] image_length_i,
  output wamsl_pkg::out_item_t        res_o
);
  import wamsl_pkg::*;

  localparam int PW = LENGTH_BITS + 1;

  logic [LENGTH_BITS-1:0] pos_q, pos_d;
  phase_e                 ph_q, ph_d;
  logic                   aot_q, aot_d, mok_q, mok_d, fin_q, fin_d;
  logic [31:0]            acc_q, acc_d, rem_q, rem_d, kind_q, kind_d, nlen_q, nlen_d;
  logic [2:0]             cnt_q, cnt_d;
  logic [3:0]             nidx_q, nidx_d;
  logic                   nm_q, nm_d;

  logic [7:0]  b;
  logic [PW-1:0] p1;
  logic [33:0] endsum;
  logic [31:0] leb_or, rem_m1;
  logic [4:0]  sh7;
  logic [4:0]  sh8;
  logic        nm_now;

  always_comb begin
    pos_d = pos_q; ph_d = ph_q; aot_d = aot_q; mok_d = mok_q; fin_d = fin_q;
    acc_d = acc_q; rem_d = rem_q; kind_d = kind_q; nlen_d = nlen_q;
    cnt_d = cnt_q; nidx_d = nidx_q; nm_d = nm_q;
    res_o = '0;
    b = item_i.image_byte;
    if (item_i.start_req) begin
      pos_d = '0; ph_d = PH_MAGIC; aot_d = 1'b0; mok_d = 1'b1; acc_d = '0; cnt_d = '0;
      rem_d = '0; kind_d = '0; nlen_d = '0; nidx_d = '0; nm_d = 1'b1; fin_d = 1'b0;
    end
    p1     = {1'b0, pos_d} + PW'(1);
    sh7    = 5'(7 * cnt_d);
    sh8    = {cnt_d[1:0], 3'b000};
    leb_or = acc_d | (32'({1'b0, b[6:0]}) << sh7);
    rem_m1 = rem_d - 32'd1;
    endsum = 34'(p1) + 34'(leb_or);
    nm_now = 1'b0;

    if (!fin_d) begin
      if (pos_d == '0 && image_length_i < LENGTH_BITS'(8)) begin
        fin_d = 1'b1; res_o.done_res = 1'b1; res_o.status = ST_BAD_MAGIC;
      end else if (pos_d >= image_length_i) begin
        fin_d = 1'b1; res_o.done_res = 1'b1; res_o.status = ST_NOT_FOUND;
      end else begin
        case (ph_d)
          PH_MAGIC: begin
            if (pos_d < LENGTH_BITS'(4)) begin
              if (pos_d[1:0] == 2'd2) begin
                if (b == 8'h6F) aot_d = 1'b1;
                else if (b != 8'h73) mok_d = 1'b0;
              end else if (b != magic_char(aot_d, pos_d[1:0])) begin
                mok_d = 1'b0;
              end
              if (pos_d[1:0] == 2'd3 && !mok_d) begin
                fin_d = 1'b1; res_o.done_res = 1'b1; res_o.status = ST_BAD_MAGIC;
              end
            end else if (pos_d == LENGTH_BITS'(7)) begin
              if (aot_d) begin
                ph_d = PH_A_HDR; cnt_d = '0; kind_d = '0; rem_d = '0;
              end else ph_d = PH_W_ID;
            end
          end
          PH_W_ID: begin
            kind_d = {24'd0, b}; acc_d = '0; cnt_d = '0; ph_d = PH_W_SIZE;
          end
          PH_W_SIZE: begin
            acc_d = leb_or; cnt_d = cnt_d + 3'd1;
            if ((b & LebMore) == 8'd0) begin
              if (endsum > 34'(image_length_i)) begin
                fin_d = 1'b1; res_o.done_res = 1'b1; res_o.status = ST_MALFORMED;
              end else begin
                rem_d = leb_or;
                if (leb_or == 32'd0) ph_d = PH_W_ID;
                else if (kind_d == 32'd0) begin
                  acc_d = '0; cnt_d = '0; ph_d = PH_W_NAMELEN;
                end else ph_d = PH_SKIP;
              end
            end else if (cnt_d >= 3'd5) begin
              fin_d = 1'b1; res_o.done_res = 1'b1; res_o.status = ST_MALFORMED;
            end
          end
          PH_W_NAMELEN: begin
            rem_d = rem_m1; acc_d = leb_or; cnt_d = cnt_d + 3'd1;
            if ((b & LebMore) == 8'd0) begin
              nlen_d = leb_or;
              if (leb_or > rem_m1 || leb_or != TargetLen) begin
                ph_d = (rem_m1 == 32'd0) ? PH_W_ID : PH_SKIP;
              end else begin
                ph_d = PH_NAME; nidx_d = '0; nm_d = 1'b1;
              end
            end else if (cnt_d >= 3'd5 || rem_m1 == 32'd0) begin
              ph_d = (rem_m1 == 32'd0) ? PH_W_ID : PH_SKIP;
            end
          end
          PH_SKIP: begin
            rem_d = rem_m1;
            if (rem_m1 == 32'd0) begin
              if (aot_d) begin
                ph_d = PH_A_HDR; cnt_d = '0; kind_d = '0; rem_d = '0;
              end else ph_d = PH_W_ID;
            end
          end
          PH_NAME: begin
            rem_d = rem_m1;
            nm_now = nm_d && (b == target_char(nidx_d));
            nm_d = nm_now;
            nidx_d = nidx_d + 4'd1;
            if (nidx_d >= 4'd15) begin
              if (!nm_now) begin
                if (rem_m1 == 32'd0) begin
                  if (aot_d) begin
                    ph_d = PH_A_HDR; cnt_d = '0; kind_d = '0; rem_d = '0;
                  end else ph_d = PH_W_ID;
                end else ph_d = PH_SKIP;
              end else begin
                nlen_d = nlen_d - TargetLen;
                if (nlen_d != 32'd0) ph_d = PH_TAIL;
                else if (rem_m1 == 32'd0) begin
                  fin_d = 1'b1; res_o.done_res = 1'b1; res_o.status = ST_FOUND;
                end else ph_d = PH_PAYLOAD;
              end
            end
          end
          PH_TAIL: begin
            rem_d = rem_m1; nlen_d = nlen_d - 32'd1;
            if (nlen_d == 32'd0) begin
              if (rem_m1 == 32'd0) begin
                fin_d = 1'b1; res_o.done_res = 1'b1; res_o.status = ST_FOUND;
              end else ph_d = PH_PAYLOAD;
            end
          end
          PH_PAYLOAD: begin
            res_o.payload_valid = 1'b1; res_o.payload_byte = b; rem_d = rem_m1;
            if (rem_m1 == 32'd0) begin
              fin_d = 1'b1; res_o.done_res = 1'b1; res_o.status = ST_FOUND;
            end
          end
          PH_A_HDR: begin
            if (!(cnt_d == 3'd0 && pos_d[1:0] != 2'd0)) begin
              if (!cnt_d[2]) kind_d = kind_d | (32'(b) << sh8);
              else rem_d = rem_d | (32'(b) << sh8);
              if (cnt_d < 3'd7) cnt_d = cnt_d + 3'd1;
              else begin
                cnt_d = '0;
                if (34'(p1) + 34'(rem_d) > 34'(image_length_i)) begin
                  fin_d = 1'b1; res_o.done_res = 1'b1; res_o.status = ST_NOT_FOUND;
                end else if (kind_d == AotCustomType && rem_d > 32'd8) begin
                  acc_d = '0; nlen_d = '0; ph_d = PH_A_BODYHDR;
                end else if (rem_d == 32'd0) begin
                  ph_d = PH_A_HDR; kind_d = '0;
                end else ph_d = PH_SKIP;
              end
            end
          end
          PH_A_BODYHDR: begin
            rem_d = rem_m1;
            if (!cnt_d[2]) acc_d = acc_d | (32'(b) << sh8);
            else nlen_d = nlen_d | (32'(b) << sh8);
            if (cnt_d >= 3'd5) begin
              cnt_d = '0;
              if (acc_d != 32'd0 || nlen_d > rem_m1 || nlen_d < TargetLen) begin
                if (rem_m1 == 32'd0) begin
                  ph_d = PH_A_HDR; kind_d = '0; rem_d = '0;
                end else ph_d = PH_SKIP;
              end else begin
                ph_d = PH_NAME; nidx_d = '0; nm_d = 1'b1;
              end
            end else cnt_d = cnt_d + 3'd1;
          end
          default: begin
            fin_d = 1'b1; res_o.done_res = 1'b1; res_o.status = ST_NOT_FOUND;
          end
        endcase
        if (!fin_d && p1 >= {1'b0, image_length_i}) begin
          fin_d = 1'b1; res_o.done_res = 1'b1;
          res_o.status = (ph_d == PH_W_SIZE && cnt_d != 3'd0) ? ST_MALFORMED : ST_NOT_FOUND;
        end
        pos_d = p1[LENGTH_BITS-1:0];
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pos_q <= '0; ph_q <= PH_MAGIC; aot_q <= 1'b0; mok_q <= 1'b1; fin_q <= 1'b0;
      acc_q <= '0; rem_q <= '0; kind_q <= '0; nlen_q <= '0; cnt_q <= '0;
      nidx_q <= '0; nm_q <= 1'b1;
    end else if (step_i) begin
      pos_q <= pos_d; ph_q <= ph_d; aot_q <= aot_d; mok_q <= mok_d; fin_q <= fin_d;
      acc_q <= acc_d; rem_q <= rem_d; kind_q <= kind_d; nlen_q <= nlen_d; cnt_q <= cnt_d;
      nidx_q <= nidx_d; nm_q <= nm_d;
    end
  end

endmodule
`default_nettype wire

// ----- hdl/wasm_aot_manifest_section_locator_top.sv -----
// Top level of the manifest custom-section locator.
`default_nettype none
// Streams a module image one byte per input transaction and returns one result
// transaction per byte: a manifest payload byte when inside the matching custom
// section, and a done flag with status on the byte where the scan concludes.
// One byte per cycle sustained: the input register feeds the scan logic, whose
// result and state update land in the output register in the same cycle; a
// stalled output holds the pipeline. The result sits in the output register
// once its byte has passed the input register, and is held there while the
// output stalls.
// The user must write image_length only while the block is idle; the block itself does not enforce it.
module wasm_aot_manifest_section_locator_top #(
  parameter int LENGTH_BITS = 24
) (
  input  wire logic                   clk_i,
  input  wire logic                   rst_ni,
  input  wire logic                   cfg_we_i,
  input  wire logic [LENGTH_BITS-1:0] cfg_wdata_i,
  input  wire logic                   in_valid_i,
  output logic                        in_stall_o,
  input  wire logic [7:0]             image_byte_i,
  input  wire logic                   start_req_i,
  output logic                        out_valid_o,
  input  wire logic                   out_stall_i,
  output logic                        payload_valid_o,
  output logic [7:0]                  payload_byte_o,
  output logic                        done_res_o,
  output logic [1:0]                  status_o
);
  import wamsl_pkg::*;

  logic [LENGTH_BITS-1:0] len_q;
  logic                   iv_q, ov_q;
  in_item_t               in_q;
  out_item_t              res, out_q;
  logic                   adv, step;

  // Stage 2 advances when the output slot is free or being drained.
  assign adv        = !ov_q || !out_stall_i;
  assign step       = iv_q && adv;
  assign in_stall_o = iv_q && !adv;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      len_q <= '0;
    end else if (cfg_we_i) begin
      len_q <= cfg_wdata_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      iv_q <= 1'b0;
      ov_q <= 1'b0;
    end else begin
      if (adv) ov_q <= iv_q;
      if (!in_stall_o) iv_q <= in_valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (!in_stall_o && in_valid_i) begin
      in_q.image_byte <= image_byte_i;
      in_q.start_req  <= start_req_i;
    end
    if (step) out_q <= res;
  end

  wamsl_scan #(.LENGTH_BITS(LENGTH_BITS)) u_scan (
    .clk_i,
    .rst_ni,
    .step_i         (step),
    .item_i         (in_q),
    .image_length_i (len_q),
    .res_o          (res)
  );

  assign out_valid_o     = ov_q;
  assign payload_valid_o = out_q.payload_valid;
  assign payload_byte_o  = out_q.payload_byte;
  assign done_res_o      = out_q.done_res;
  assign status_o        = out_q.status;

endmodule
`default_nettype wire
